### src/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and the arctangent table for the lidar polar to
// cartesian core.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int RANGE_W     = 22;
  localparam int ANGLE_W     = 32;
  localparam int SCALE_W     = 24;
  localparam int POINT_W     = 32;
  localparam int DIST_W      = 30;
  localparam int ROT_W       = 34;
  localparam int ATAN_IDX_W  = 5;
  localparam int ATAN_ENTRIES = 30;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // 0.1 m in 1/65536 m
  localparam logic [RANGE_W:0]   MARGIN_UNITS = 23'd6554;
  // inverse CORDIC gain, Q0.32
  localparam logic [31:0]        GAIN_INV_Q32 = 32'd2608131496;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_M   = 3'd4;

  typedef struct packed {
    logic [RANGE_W-1:0] range_floor;
    logic [RANGE_W-1:0] range_ceiling;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] angle_step;
    logic [SCALE_W-1:0] cells_per_metre;
  } cfg_t;

  typedef struct packed {
    logic                  load;
    logic                  scale;
    logic                  gain;
    logic                  rot;
    logic [ATAN_IDX_W-1:0] step_idx;
    logic                  load_out;
  } cmd_t;

  typedef struct packed {
    logic keep;
  } sts_t;

  function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### src/lpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpc_cfg_regs
// Configuration register bank written through the cfg channel.
// ----------------------------------------------------------------------------
module lpc_cfg_regs
  import lpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_FLOOR:   cfg_nxt.range_floor     = cfg_data[RANGE_W-1:0];
        REG_RANGE_CEILING: cfg_nxt.range_ceiling   = cfg_data[RANGE_W-1:0];
        REG_START_ANGLE:   cfg_nxt.start_angle     = cfg_data[ANGLE_W-1:0];
        REG_ANGLE_STEP:    cfg_nxt.angle_step      = cfg_data[ANGLE_W-1:0];
        REG_CELLS_PER_M:   cfg_nxt.cells_per_metre = cfg_data[SCALE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_floor     <= 22'd0;
      cfg_r.range_ceiling   <= 22'd1966080;
      cfg_r.start_angle     <= 32'h80000000;
      cfg_r.angle_step      <= 32'd2982616;
      cfg_r.cells_per_metre <= 24'd2621440;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/lpc_ctrl.sv
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: accept, scale, gain, rotation steps, output handoff.
// ----------------------------------------------------------------------------
module lpc_ctrl
  import lpc_pkg::*;
#(
  parameter int STEPS = 18
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(STEPS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_GAIN  = 3'd2;
  localparam logic [2:0] ST_ROT   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.step_idx = ATAN_IDX_W'(cnt_r);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept && sts.keep) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/lpc_datapath.sv
// ----------------------------------------------------------------------------
// lpc_datapath
// Beam angle tracking, range gate, scaling, gain and iterative CORDIC rotation.
// ----------------------------------------------------------------------------
module lpc_datapath
  import lpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [RANGE_W-1:0]        in_range_sample,
  input  logic                      in_scan_start,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y
);

  logic [ANGLE_W-1:0]        beam_angle_r;
  logic [ANGLE_W-1:0]        angle_r;
  logic [RANGE_W-1:0]        range_r;
  logic [DIST_W-1:0]         dist_r;
  logic signed [ROT_W-1:0]   x_r, y_r, z_r;
  logic signed [POINT_W-1:0] px_r, py_r;

  logic [ANGLE_W-1:0]            angle_cur;
  logic [RANGE_W+SCALE_W-1:0]    scale_sum;
  logic [DIST_W+32-1:0]          gain_sum;
  logic [DIST_W-1:0]             dist_k;
  logic                          fold;
  logic [ANGLE_W-1:0]            angle_fold;
  logic signed [ROT_W-1:0]       x_init;
  logic signed [ROT_W-1:0]       xs, ys, atan_v;
  logic                          dir;

  assign angle_cur = in_scan_start ? cfg.start_angle : beam_angle_r;

  assign sts.keep = (in_range_sample > cfg.range_floor) &&
                    (({1'b0, in_range_sample} + MARGIN_UNITS) < {1'b0, cfg.range_ceiling});

  assign scale_sum = (range_r * cfg.cells_per_metre) + (RANGE_W+SCALE_W)'(32'h8000);
  assign gain_sum  = (dist_r * GAIN_INV_Q32) + (DIST_W+32)'(32'h80000000);
  assign dist_k    = gain_sum[DIST_W+31:32];

  assign fold       = angle_r[31] ^ angle_r[30];
  assign angle_fold = fold ? {~angle_r[31], angle_r[30:0]} : angle_r;
  assign x_init     = fold ? -signed'({4'b0, dist_k}) : signed'({4'b0, dist_k});

  assign xs     = x_r >>> cmd.step_idx;
  assign ys     = y_r >>> cmd.step_idx;
  assign atan_v = signed'({2'b0, atan_entry(cmd.step_idx)});
  assign dir    = !z_r[ROT_W-1];

  function automatic logic signed [POINT_W-1:0] sat(input logic signed [ROT_W-1:0] v);
    logic signed [POINT_W-1:0] r;
    if ((v[ROT_W-1:POINT_W-1] == '0) || (v[ROT_W-1:POINT_W-1] == '1)) r = v[POINT_W-1:0];
    else if (v[ROT_W-1]) r = {1'b1, {(POINT_W-1){1'b0}}};
    else r = {1'b0, {(POINT_W-1){1'b1}}};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= '0;
    end else if (cmd.load) begin
      beam_angle_r <= angle_cur + cfg.angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= angle_cur;
      range_r <= in_range_sample;
    end
    if (cmd.scale) dist_r <= scale_sum[RANGE_W+SCALE_W-1:16];
    if (cmd.gain) begin
      x_r <= x_init;
      y_r <= '0;
      z_r <= signed'({{2{angle_fold[31]}}, angle_fold});
    end else if (cmd.rot) begin
      x_r <= dir ? (x_r - ys) : (x_r + ys);
      y_r <= dir ? (y_r + xs) : (y_r - xs);
      z_r <= dir ? (z_r - atan_v) : (z_r + atan_v);
    end
    if (cmd.load_out) begin
      px_r <= sat(x_r);
      py_r <= sat(y_r);
    end
  end

  assign out_point_x = px_r;
  assign out_point_y = py_r;

endmodule

### src/lidar_polar_to_cartesian_core.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_core
// Converts lidar range samples to map-cell x,y points via CORDIC rotation.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | in_range_sample, in_scan_start
//   out     | output    | out_valid/out_stall | out_point_x, out_point_y
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A kept sample stalls the input from accept through scale, gain, the rotation
// steps (ROTATION_STEPS, capped at 30, one micro-rotation per cycle) and output
// load, so no new sample is taken while one is in work; the load waits while an
// earlier point is stalled. A rejected sample does not stall the input.
// Reset is synchronous; it clears the sequencer and beam angle and sets the
// config registers to their defaults.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian_core
  import lpc_pkg::*;
#(
  parameter int ROTATION_STEPS = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RANGE_W-1:0]        in_range_sample,
  input  logic                      in_scan_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int STEPS = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STEPS;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  lpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpc_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_range_sample (in_range_sample),
    .in_scan_start   (in_scan_start),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y)
  );

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rot || cmd.scale || cmd.gain) |-> in_stall)
    else $error("input open while item in work");

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scale, cmd.gain, cmd.rot, cmd.load_out}))
    else $error("overlapping datapath commands");

endmodule
